[rtl/core/led_bar_frame_driver_assert.svh]
// ---------------------------------------------------------------------------
// led_bar_frame_driver_assert.svh
// assertion macros used by the checker file of the led bar frame driver
// ---------------------------------------------------------------------------
`ifndef LED_BAR_FRAME_DRIVER_ASSERT_SVH
`define LED_BAR_FRAME_DRIVER_ASSERT_SVH

// same-cycle implication, off while in reset
`define LBFD_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lbfd assertion failed");

// next-cycle implication, off while in reset
`define LBFD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lbfd assertion failed");

// next-cycle implication, also checked through reset
`define LBFD_ASSERT_NEXT_ALWAYS(lbl, clk, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("lbfd assertion failed");

`endif

[rtl/core/lbfd_pkg.sv]
// ---------------------------------------------------------------------------
// lbfd_pkg
// shared types, codes and helpers of the led bar frame driver
// ---------------------------------------------------------------------------
package lbfd_pkg;

  // op codes of an input item
  localparam logic [2:0] OP_SET_LEVEL   = 3'd0;
  localparam logic [2:0] OP_SET_SEGMENT = 3'd1;
  localparam logic [2:0] OP_TOGGLE      = 3'd2;
  localparam logic [2:0] OP_SET_BITS    = 3'd3;
  localparam logic [2:0] OP_REFRESH     = 3'd4;

  // register indexes
  localparam logic REG_REVERSE_ORDER = 1'b0;
  localparam logic REG_COMMAND_WORD  = 1'b1;

  localparam int MASK_W   = 10;   // mask and lit bits
  localparam int IDX_W    = 5;    // segment index, up to 32 segments
  localparam int EIGHTHS  = 8;
  localparam logic [7:0] FULL_PATTERN = 8'hFF;

  typedef enum logic [2:0] {
    K_LEVEL,
    K_SEGMENT,
    K_TOGGLE,
    K_BITS,
    K_REFRESH
  } kind_t;

  // classified operation, passed through the queue
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        level;     // already saturated
    logic [IDX_W-1:0]  idx;       // zero-based, already clamped
    logic [7:0]        pattern;   // set segment pattern
    logic [MASK_W-1:0] mask;
  } cmd_t;

  typedef struct packed {
    logic        reverse_order;
    logic [15:0] command_word;
  } cfg_t;

  // pattern for b eighths, full at 8 and above
  function automatic logic [7:0] eighths_pattern(input logic [7:0] b);
    logic [8:0] one_hot;
    one_hot = 9'd1 << b[2:0];
    if (b >= 8'(EIGHTHS)) begin
      return FULL_PATTERN;
    end
    return 8'(one_hot - 9'd1);
  endfunction

endpackage

[rtl/core/lbfd_if.sv]
// ---------------------------------------------------------------------------
// lbfd_if
// valid/ready channels of the led bar frame driver: update items and words
// ---------------------------------------------------------------------------
interface lbfd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] fill_level;
  logic [7:0] segment_index;
  logic [7:0] brightness_eighths;
  logic [9:0] segment_mask;

  modport source (
    output valid, op, fill_level, segment_index, brightness_eighths, segment_mask,
    input  ready
  );
  modport sink (
    input  valid, op, fill_level, segment_index, brightness_eighths, segment_mask,
    output ready
  );
endinterface

interface lbfd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_word;
  logic        frame_last;
  logic [9:0]  lit_mask;

  modport source (
    output valid, frame_word, frame_last, lit_mask,
    input  ready
  );
  modport sink (
    input  valid, frame_word, frame_last, lit_mask,
    output ready
  );
endinterface

[rtl/core/lbfd_front.sv]
// ---------------------------------------------------------------------------
// lbfd_front
// accepts update items and classifies them into queue commands
// ---------------------------------------------------------------------------
module lbfd_front #(
  parameter int SEGMENTS = 10
) (
  lbfd_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           push,
  output lbfd_pkg::cmd_t cmd
);

  localparam int LEVEL_SAT = lbfd_pkg::EIGHTHS * SEGMENTS;

  logic [8:0]                  level9;
  logic [lbfd_pkg::IDX_W-1:0]  idx;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // saturate level to the bar length
  always_comb begin
    level9 = {1'b0, in_ch.fill_level};
    if (level9 > 9'(LEVEL_SAT)) begin
      level9 = 9'(LEVEL_SAT);
    end
  end

  // clamp one-based index to 1..SEGMENTS, then make it zero-based
  always_comb begin
    if (in_ch.segment_index == 8'd0) begin
      idx = '0;
    end else if (in_ch.segment_index > 8'(SEGMENTS)) begin
      idx = lbfd_pkg::IDX_W'(SEGMENTS - 1);
    end else begin
      idx = lbfd_pkg::IDX_W'(in_ch.segment_index - 8'd1);
    end
  end

  always_comb begin
    cmd.level   = level9[7:0];
    cmd.idx     = idx;
    cmd.pattern = lbfd_pkg::eighths_pattern(in_ch.brightness_eighths);
    cmd.mask    = in_ch.segment_mask;
    unique case (in_ch.op)
      lbfd_pkg::OP_SET_LEVEL:   cmd.kind = lbfd_pkg::K_LEVEL;
      lbfd_pkg::OP_SET_SEGMENT: cmd.kind = lbfd_pkg::K_SEGMENT;
      lbfd_pkg::OP_TOGGLE:      cmd.kind = lbfd_pkg::K_TOGGLE;
      lbfd_pkg::OP_SET_BITS:    cmd.kind = lbfd_pkg::K_BITS;
      default:                  cmd.kind = lbfd_pkg::K_REFRESH;
    endcase
  end

endmodule

[rtl/core/lbfd_queue.sv]
// ---------------------------------------------------------------------------
// lbfd_queue
// two-entry command queue between front and back
// ---------------------------------------------------------------------------
module lbfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lbfd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output lbfd_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           empty
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  lbfd_pkg::cmd_t   entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r,  count_nxt;

  assign full     = (count_r == (PW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/core/lbfd_back.sv]
// ---------------------------------------------------------------------------
// lbfd_back
// applies one command to the segment patterns and streams out its frame
// ---------------------------------------------------------------------------
module lbfd_back #(
  parameter int SEGMENTS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lbfd_pkg::cfg_t cfg,
  input  lbfd_pkg::cmd_t head_cmd,
  input  logic           q_empty,
  output logic           pop,
  lbfd_out_if.source     out_ch
);

  localparam int WORDS  = SEGMENTS + 3;
  localparam int KW     = $clog2(WORDS);
  localparam int SIW    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam logic [KW-1:0] LAST_K = KW'(WORDS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_EMIT
  } state_t;

  state_t                       state_r;
  lbfd_pkg::cmd_t               cmd_r;
  logic [7:0]                   pat_r   [SEGMENTS];
  logic [7:0]                   pat_nxt [SEGMENTS];
  logic [KW-1:0]                k_r;
  logic                         out_valid_r;
  logic [15:0]                  word_r;
  logic                         last_r;
  logic [lbfd_pkg::MASK_W-1:0]  lit_r;

  logic [lbfd_pkg::MASK_W-1:0]  lit;
  logic [KW-1:0]                pos;
  logic [KW-1:0]                seg_sel;
  logic [15:0]                  word_sel;
  logic                         slot_free;

  assign pop       = (state_r == ST_IDLE) && !q_empty;
  assign slot_free = !out_valid_r || out_ch.ready;

  // per-segment update for the command in hand
  for (genvar g = 0; g < SEGMENTS; g++) begin : g_seg
    logic [8:0] lv;
    logic [8:0] diff;
    logic       mask_bit;

    if (g < lbfd_pkg::MASK_W) begin : g_mask
      assign mask_bit = cmd_r.mask[g];
    end else begin : g_nomask
      assign mask_bit = 1'b0;
    end

    assign lv   = {1'b0, cmd_r.level};
    assign diff = lv - 9'(lbfd_pkg::EIGHTHS * g);

    always_comb begin
      pat_nxt[g] = pat_r[g];
      case (cmd_r.kind)
        lbfd_pkg::K_LEVEL: begin
          if (lv >= 9'(lbfd_pkg::EIGHTHS * (g + 1))) begin
            pat_nxt[g] = lbfd_pkg::FULL_PATTERN;
          end else if (lv > 9'(lbfd_pkg::EIGHTHS * g)) begin
            pat_nxt[g] = lbfd_pkg::eighths_pattern(diff[7:0]);
          end else begin
            pat_nxt[g] = 8'h00;
          end
        end
        lbfd_pkg::K_SEGMENT: begin
          if (cmd_r.idx == lbfd_pkg::IDX_W'(g)) begin
            pat_nxt[g] = cmd_r.pattern;
          end
        end
        lbfd_pkg::K_TOGGLE: begin
          if (cmd_r.idx == lbfd_pkg::IDX_W'(g)) begin
            pat_nxt[g] = (pat_r[g] != 8'h00) ? 8'h00 : lbfd_pkg::FULL_PATTERN;
          end
        end
        lbfd_pkg::K_BITS: begin
          pat_nxt[g] = {8{mask_bit}};
        end
        default: begin
          pat_nxt[g] = pat_r[g];
        end
      endcase
    end
  end

  // lit mask covers the first ten segments only
  for (genvar g = 0; g < lbfd_pkg::MASK_W; g++) begin : g_lit
    if (g < SEGMENTS) begin : g_on
      assign lit[g] = |pat_r[g];
    end else begin : g_off
      assign lit[g] = 1'b0;
    end
  end

  // word for slot k: command, channel words, two zero words
  always_comb begin
    pos      = k_r - 1'b1;
    seg_sel  = cfg.reverse_order ? (KW'(SEGMENTS - 1) - pos) : pos;
    word_sel = 16'h0000;
    if (k_r == '0) begin
      word_sel = cfg.command_word;
    end else if (k_r <= KW'(SEGMENTS)) begin
      word_sel = {8'h00, pat_r[seg_sel[SIW-1:0]]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SEGMENTS; i++) begin
        pat_r[i] <= 8'h00;
      end
    end else begin
      if (state_r == ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
        word_r      <= word_sel;
        last_r      <= (k_r == LAST_K);
        lit_r       <= lit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            state_r <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          for (int i = 0; i < SEGMENTS; i++) begin
            pat_r[i] <= pat_nxt[i];
          end
          k_r     <= '0;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (k_r == LAST_K) begin
              state_r <= ST_IDLE;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // command taken from the queue head
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head_cmd;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_word = word_r;
  assign out_ch.frame_last = last_r;
  assign out_ch.lit_mask   = lit_r;

endmodule

[rtl/core/led_bar_frame_driver.sv]
// ---------------------------------------------------------------------------
// led_bar_frame_driver
// ten-segment led bar driver: keeps segment patterns, applies one update per
// item and streams a frame of sixteen-bit words for each update
// ---------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// in_ch     sink       valid/ready          op, fill_level, segment_index,
//                                           brightness_eighths, segment_mask
// out_ch    source     valid/ready          frame_word, frame_last, lit_mask
// apb       slave      psel/penable/pready  paddr, pwdata, prdata
//
// each item is handled in order: the queue is popped, the patterns are updated,
// and the word emitter sends the command word, the segment words and two zero
// words of the frame, one word a cycle while out_ch is ready
// in_ch is taken while the two-entry command queue has room
// a stall on out_ch holds the current word and stops the emitter
// rst_n (synchronous) clears the patterns, the registers and all control
//
module led_bar_frame_driver #(
  parameter int SEGMENTS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  lbfd_in_if.sink     in_ch,
  lbfd_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic        reverse_r;
  logic [15:0] command_r;
  logic        cfg_wr;
  logic        reg_sel;

  lbfd_pkg::cfg_t cfg;

  // queue signals
  lbfd_pkg::cmd_t push_cmd;
  lbfd_pkg::cmd_t head_cmd;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // register i sits at byte address 4*i
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r <= 1'b0;
      command_r <= 16'h0000;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        lbfd_pkg::REG_REVERSE_ORDER: reverse_r <= pwdata[0];
        lbfd_pkg::REG_COMMAND_WORD:  command_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      lbfd_pkg::REG_REVERSE_ORDER: prdata = {31'h0, reverse_r};
      lbfd_pkg::REG_COMMAND_WORD:  prdata = {16'h0, command_r};
      default:                     prdata = 32'h0;
    endcase
  end

  assign cfg.reverse_order = reverse_r;
  assign cfg.command_word  = command_r;

  // front: accept and classify items
  lbfd_front #(
    .SEGMENTS (SEGMENTS)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  // queue lets the front keep accepting while a frame streams out
  lbfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: update patterns, then emit the frame word by word
  lbfd_back #(
    .SEGMENTS (SEGMENTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .head_cmd (head_cmd),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

[rtl/core/lbfd_checker.sv]
// ---------------------------------------------------------------------------
// lbfd_checker
// port-level checks of the led bar frame driver, bound to the top level
// ---------------------------------------------------------------------------
`include "led_bar_frame_driver_assert.svh"

module lbfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] frame_word,
  input logic        frame_last,
  input logic [9:0]  lit_mask
);

  // stalled word holds
  `LBFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(frame_word) && $stable(frame_last))

  // final word of a frame is a zero pad word
  `LBFD_ASSERT_NOW(a_last_zero, clk, rst_n, out_valid && frame_last, frame_word == 16'h0000)

  // lit mask stays put inside a frame
  `LBFD_ASSERT_NEXT(a_lit_frame, clk, rst_n, out_valid && out_ready && !frame_last, $stable(lit_mask))

  // nothing is offered right after reset
  `LBFD_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid)

endmodule

bind led_bar_frame_driver lbfd_checker u_lbfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .frame_word (out_ch.frame_word),
  .frame_last (out_ch.frame_last),
  .lit_mask   (out_ch.lit_mask)
);

[verif/lbfd_frame_checker.sv]
// ---------------------------------------------------------------------------
// lbfd_frame_checker
// watches the update and frame channels and the register port, keeps its
// own copy of the segment patterns and compares every frame word
// ---------------------------------------------------------------------------
module lbfd_frame_checker
  import lbfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lbfd_in_if          in_mon,
  lbfd_out_if         out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG_COUNT = 10;
  localparam int FRAME_LEN = SEG_COUNT + 3;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic [9:0]  lit;
  } frame_word_t;

  frame_word_t expected_words[$];
  logic [7:0]  seg_pat [SEG_COUNT];
  logic        rev_order;
  logic [15:0] cmd_word;

  function automatic logic [7:0] eighths_to_pattern(input int unsigned b);
    if (b >= EIGHTHS) begin
      return FULL_PATTERN;
    end
    return 8'((1 << b) - 1);
  endfunction

  // apply one update to the pattern copy and queue the frame it causes
  task automatic predict_frame(input logic [2:0] op, input logic [7:0] level,
                               input logic [7:0] idx_raw, input logic [7:0] bright,
                               input logic [9:0] mask);
    int unsigned lvl;
    int unsigned seg;
    int unsigned base;
    logic [9:0]  lit;
    frame_word_t w;
    seg = (idx_raw == 8'd0) ? 0 : ((idx_raw > 8'(SEG_COUNT)) ? SEG_COUNT - 1 : idx_raw - 1);
    case (op)
      OP_SET_LEVEL: begin
        lvl = (level > 8'(EIGHTHS * SEG_COUNT)) ? EIGHTHS * SEG_COUNT : level;
        for (int i = 0; i < SEG_COUNT; i++) begin
          base = EIGHTHS * i;
          if (lvl >= base + EIGHTHS) seg_pat[i] = FULL_PATTERN;
          else if (lvl > base)       seg_pat[i] = eighths_to_pattern(lvl - base);
          else                       seg_pat[i] = 8'h00;
        end
      end
      OP_SET_SEGMENT: begin
        seg_pat[seg] = eighths_to_pattern((bright > 8'(EIGHTHS)) ? EIGHTHS : bright);
      end
      OP_TOGGLE: begin
        seg_pat[seg] = (seg_pat[seg] != 8'h00) ? 8'h00 : FULL_PATTERN;
      end
      OP_SET_BITS: begin
        for (int i = 0; i < SEG_COUNT; i++) begin
          seg_pat[i] = mask[i] ? FULL_PATTERN : 8'h00;
        end
      end
      default: begin
        // refresh and the unused codes leave the patterns alone
      end
    endcase
    for (int i = 0; i < SEG_COUNT; i++) begin
      lit[i] = (seg_pat[i] != 8'h00);
    end
    for (int k = 0; k < FRAME_LEN; k++) begin
      if (k == 0)              w.word = cmd_word;
      else if (k <= SEG_COUNT) w.word = {8'h00, seg_pat[rev_order ? SEG_COUNT - k : k - 1]};
      else                     w.word = 16'h0000;
      w.last = (k == FRAME_LEN - 1);
      w.lit  = lit;
      expected_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    frame_word_t exp_w;
    frame_word_t got_w;
    if (!rst_n) begin
      for (int i = 0; i < SEG_COUNT; i++) seg_pat[i] = 8'h00;
      rev_order = 1'b0;
      cmd_word  = 16'h0000;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got_w = '{out_mon.frame_word, out_mon.frame_last, out_mon.lit_mask};
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected frame word %h last %b lit %h", got_w.word, got_w.last,
                     got_w.lit);
        end else begin
          exp_w = expected_words.pop_front();
          if (got_w !== exp_w) begin
            fail_count++;
            if (fail_count <= 10)
              $display("frame word mismatch: expected word %h last %b lit %h, got word %h last %b lit %h",
                       exp_w.word, exp_w.last, exp_w.lit, got_w.word, got_w.last, got_w.lit);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_COMMAND_WORD) cmd_word = pwdata[15:0];
        else                              rev_order = pwdata[0];
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_frame(in_mon.op, in_mon.fill_level, in_mon.segment_index,
                      in_mon.brightness_eighths, in_mon.segment_mask);
      end
    end
    words_due = expected_words.size();
  end

endmodule

[verif/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// testbench of the led bar frame driver: drives update items and register
// writes, stalls the frame channel at random and lets the frame checker
// predict and compare every word; a directed pass covers level and index
// extremes, saturation, toggling, masks and unused op codes, then random
// phases run under several direction and command word settings
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lbfd_pkg::*;

  localparam int STALL_LIMIT = 3000;   // cycles with no handshake at all

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          words_due;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;    // no idling on either side while set

  lbfd_in_if  in_ch ();
  lbfd_out_if out_ch ();

  always #4 clk = ~clk;

  led_bar_frame_driver DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lbfd_frame_checker frame_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  // frame sink: ready drops at random, about one time in ten, unless calm
  always @(negedge clk) begin
    out_ch.ready <= rst_n && (calm || $urandom_range(0, 99) >= 10);
  end

  // watchdog: any handshake on any port restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_update(input logic [2:0] op, input logic [7:0] level,
                             input logic [7:0] idx, input logic [7:0] bright,
                             input logic [9:0] mask);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 10) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      // idle gap before this item
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.op                 <= op;
    in_ch.fill_level         <= level;
    in_ch.segment_index      <= idx;
    in_ch.brightness_eighths <= bright;
    in_ch.segment_mask       <= mask;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // random item, mostly in-range values with some full-width ones
  task automatic random_update();
    int          pick;
    logic [2:0]  op;
    logic [7:0]  level;
    logic [7:0]  idx;
    logic [7:0]  bright;
    pick = $urandom_range(0, 99);
    if (pick < 18)      op = OP_SET_LEVEL;
    else if (pick < 40) op = OP_SET_SEGMENT;
    else if (pick < 58) op = OP_TOGGLE;
    else if (pick < 76) op = OP_SET_BITS;
    else if (pick < 90) op = OP_REFRESH;
    else                op = 3'($urandom_range(5, 7));   // unused codes
    level  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 80)) : 8'($urandom);
    idx    = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 10)) : 8'($urandom);
    bright = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 8)) : 8'($urandom);
    send_update(op, level, idx, bright, 10'($urandom));
  endtask

  // lower valid and wait until every frame word has come out
  task automatic wait_frames_done();
    in_ch.valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write: setup then access, returns at a falling edge after psel drops
  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // registers change only with the block idle
  task automatic set_config(input logic rev, input logic [15:0] cmd);
    wait_frames_done();
    write_reg(REG_REVERSE_ORDER, {31'd0, rev});
    write_reg(REG_COMMAND_WORD, {16'd0, cmd});
  endtask

  initial begin
    in_ch.valid              = 1'b0;
    in_ch.op                 = OP_REFRESH;
    in_ch.fill_level         = 8'd0;
    in_ch.segment_index      = 8'd0;
    in_ch.brightness_eighths = 8'd0;
    in_ch.segment_mask       = 10'd0;
    out_ch.ready             = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = 3'd0;
    pwdata                   = 32'd0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pass, forward order, all-zero command word
    set_config(1'b0, 16'h0000);
    send_update(OP_REFRESH,     8'd0,   8'd0,   8'd0,   10'h000);  // frame right after reset
    send_update(OP_SET_LEVEL,   8'd80,  8'hFF,  8'hFF,  10'h3FF);  // full bar
    send_update(OP_SET_LEVEL,   8'd255, 8'd0,   8'd0,   10'h000);  // level saturates
    send_update(OP_SET_LEVEL,   8'd13,  8'd0,   8'd0,   10'h000);  // partial segment
    send_update(OP_SET_LEVEL,   8'd8,   8'd0,   8'd0,   10'h000);  // exact boundary
    send_update(OP_SET_LEVEL,   8'd79,  8'd0,   8'd0,   10'h000);
    send_update(OP_SET_LEVEL,   8'd0,   8'd0,   8'd0,   10'h000);  // empty bar
    send_update(OP_SET_SEGMENT, 8'd0,   8'd0,   8'd255, 10'h000);  // index below range
    send_update(OP_SET_SEGMENT, 8'hFF,  8'd255, 8'd7,   10'h000);  // index above range
    send_update(OP_SET_SEGMENT, 8'd0,   8'd5,   8'd3,   10'h000);
    send_update(OP_SET_SEGMENT, 8'd0,   8'd10,  8'd8,   10'h000);
    send_update(OP_SET_SEGMENT, 8'd0,   8'd2,   8'd9,   10'h000);  // brightness saturates
    send_update(OP_SET_SEGMENT, 8'd0,   8'd10,  8'd0,   10'h000);  // zero brightness
    send_update(OP_TOGGLE,      8'd0,   8'd0,   8'd0,   10'h000);  // lit segment goes dark
    send_update(OP_TOGGLE,      8'd0,   8'd200, 8'd0,   10'h000);  // dark segment lights
    send_update(OP_TOGGLE,      8'd0,   8'd10,  8'd0,   10'h000);
    send_update(OP_SET_BITS,    8'd0,   8'd0,   8'd0,   10'h3FF);
    send_update(OP_SET_BITS,    8'd0,   8'd0,   8'd0,   10'h2A5);
    send_update(OP_SET_BITS,    8'd0,   8'd0,   8'd0,   10'h000);
    send_update(OP_SET_BITS,    8'd0,   8'd0,   8'd0,   10'h15A);
    send_update(3'd5,           8'd80,  8'd1,   8'd8,   10'h3FF);  // unused codes refresh
    send_update(3'd6,           8'd0,   8'd0,   8'd0,   10'h000);
    send_update(3'd7,           8'hFF,  8'hFF,  8'hFF,  10'h3FF);

    // random phases under different settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_config(1'b1, 16'hFFFF);
        1:       set_config(1'b0, 16'h8000);
        default: set_config(1'($urandom), 16'($urandom));
      endcase
      calm = (phase == 1);   // one long stretch with no idling anywhere
      for (int n = 0; n < 35; n++) begin
        if (phase == 2 && n == 17) begin
          // sender holds off until the frames in flight are all out
          wait_frames_done();
        end
        random_update();
      end
      calm = 1'b0;
    end

    // drain, then idle on to catch anything stray
    wait_frames_done();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[led_bar_frame_driver.f]
+incdir+rtl/core
rtl/core/lbfd_pkg.sv
rtl/core/lbfd_if.sv
rtl/core/lbfd_front.sv
rtl/core/lbfd_queue.sv
rtl/core/lbfd_back.sv
rtl/core/led_bar_frame_driver.sv
rtl/core/lbfd_checker.sv
verif/lbfd_frame_checker.sv
verif/tb_top.sv
